### hw/rtl/triangle_pixel_coverage_shader_defines.svh
// Assertion macros for the triangle coverage shader.
// Needs a clock i_clk and an active-low reset i_rst_n in the scope of use.
`ifndef TRIANGLE_PIXEL_COVERAGE_SHADER_DEFINES_SVH
`define TRIANGLE_PIXEL_COVERAGE_SHADER_DEFINES_SVH

// Same-cycle implication.
`define TPCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tpcs_pkg.sv
// Shared widths and register codes of the triangle coverage shader.
// No dependencies.
`timescale 1ns / 1ps

package tpcs_pkg;

    localparam int VERT_W    = 16;
    localparam int RGB_W     = 24;
    localparam int PIX_W     = 12;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_V0X = 3'd0,
        CFG_V0Y = 3'd1,
        CFG_V1X = 3'd2,
        CFG_V1Y = 3'd3,
        CFG_V2X = 3'd4,
        CFG_V2Y = 3'd5,
        CFG_RGB = 3'd6
    } t_cfg_idx;

endpackage

### hw/rtl/tpcs_if.sv
// Valid/ready channel interfaces: configuration writes, pixels, results.
// Depends on tpcs_pkg.
`timescale 1ns / 1ps

interface tpcs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpcs_pkg::CFG_IDX_W-1:0]  index;
    logic [tpcs_pkg::RGB_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface tpcs_pix_if;
    logic                        valid;
    logic                        ready;
    logic [tpcs_pkg::PIX_W-1:0]  pixel_x;
    logic [tpcs_pkg::PIX_W-1:0]  pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tpcs_res_if;
    logic                       valid;
    logic                       ready;
    logic                       covered;
    logic [tpcs_pkg::CH_W-1:0]  red_out;
    logic [tpcs_pkg::CH_W-1:0]  green_out;
    logic [tpcs_pkg::CH_W-1:0]  blue_out;
    modport source (output valid, output covered, output red_out, output green_out,
                    output blue_out, input ready);
    modport sink   (input valid, input covered, input red_out, input green_out,
                    input blue_out, output ready);
endinterface

### hw/rtl/triangle_pixel_coverage_shader.sv
// Barycentric triangle coverage and shading, fully pipelined.
// Depends on tpcs_pkg, the tpcs_*_if interfaces and the defines header.
//
// Usage:
//   i_cfg  : register writes (vertices 0..2 x/y, packed fill color), always
//            ready; write only while no pixel is in flight.
//   i_pix  : one pixel coordinate per item.
//   o_res  : one result per pixel, in order: covered flag and the three
//            color channels scaled by the barycentric weights (zero when the
//            pixel is not covered).
// Throughput is one item per cycle: five arithmetic stages (edge products,
// sums, sign tests, channel multiply) are followed by eight restoring
// division stages, one quotient bit each, and the output register.
// When the receiver stalls with a result waiting, every stage holds and
// i_pix.ready drops until that result is taken; no bubbles are squeezed out.
// Reset clears the configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "triangle_pixel_coverage_shader_defines.svh"

module triangle_pixel_coverage_shader #(
    parameter int COORD_FRAC_BITS  = 4,
    parameter int PIXEL_COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpcs_cfg_if.sink    i_cfg,
    tpcs_pix_if.sink    i_pix,
    tpcs_res_if.source  o_res
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int VW  = tpcs_pkg::VERT_W;
    localparam int CHW = tpcs_pkg::CH_W;
    localparam int PU  = (PIXEL_COORD_BITS < tpcs_pkg::PIX_W) ?
                         PIXEL_COORD_BITS : tpcs_pkg::PIX_W;
    localparam int PW  = PIXEL_COORD_BITS + F + 1;
    localparam int DW  = VW + 1;
    localparam int PRW = DW + PW;
    localparam int CW  = 2 * VW + 1;
    localparam int EW  = ((PRW > CW) ? PRW : CW) + 2;
    localparam int NW  = EW + CHW;
    localparam int NS  = 5 + CHW + 1;

    // Configuration registers.
    logic signed [VW-1:0]               r_vx [0:2];
    logic signed [VW-1:0]               r_vy [0:2];
    logic [tpcs_pkg::RGB_W-1:0]         r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx  <= '{default: '0};
            r_vy  <= '{default: '0};
            r_rgb <= '0;
        end else if (i_cfg.valid) begin
            unique case (tpcs_pkg::t_cfg_idx'(i_cfg.index))
                tpcs_pkg::CFG_V0X: r_vx[0] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_V0Y: r_vy[0] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_V1X: r_vx[1] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_V1Y: r_vy[1] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_V2X: r_vx[2] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_V2Y: r_vy[2] <= i_cfg.data[VW-1:0];
                tpcs_pkg::CFG_RGB: r_rgb   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Pipeline control: one valid bit per stage, all stages move together.
    logic [NS-1:0] r_vld;
    logic          w_en;

    assign w_en        = !r_vld[NS-1] || o_res.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_pix.valid};
        end
    end

    // Stage 1: pixel in vertex format, edge coefficients, vertex cross terms.
    logic signed [PW-1:0]  r1_px, r1_py;
    logic signed [DW-1:0]  r1_a [0:2];
    logic signed [DW-1:0]  r1_b [0:2];
    logic signed [2*VW-1:0] r1_p [0:2];
    logic signed [2*VW-1:0] r1_q [0:2];

    // Stage 2: products.
    logic signed [PRW-1:0] r2_ma [0:2];
    logic signed [PRW-1:0] r2_mb [0:2];
    logic signed [CW-1:0]  r2_c  [0:2];
    logic signed [DW:0]    r2_s  [0:2];
    logic signed [DW+VW-1:0] r2_da, r2_db;

    // Stage 3: edge values, tie-break values, denominator.
    logic signed [EW-1:0]  r3_e [0:2];
    logic signed [EW-1:0]  r3_t [0:2];
    logic signed [EW-1:0]  r3_d;

    // Stage 4: coverage and magnitudes.
    logic                  r4_cov;
    logic [EW-1:0]         r4_me [0:2];
    logic [EW-1:0]         r4_md;
    logic [2:0]            w_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px <= PW'(i_pix.pixel_x[PU-1:0]) << F;
            r1_py <= PW'(i_pix.pixel_y[PU-1:0]) << F;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_edge
        localparam int IA = (i + 1) % 3;
        localparam int IB = (i + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_a[i]  <= DW'(r_vy[IA]) - DW'(r_vy[IB]);
                r1_b[i]  <= DW'(r_vx[IB]) - DW'(r_vx[IA]);
                r1_p[i]  <= r_vx[IA] * r_vy[IB];
                r1_q[i]  <= r_vx[IB] * r_vy[IA];
                r2_ma[i] <= PRW'(r1_a[i]) * PRW'(r1_px);
                r2_mb[i] <= PRW'(r1_b[i]) * PRW'(r1_py);
                r2_c[i]  <= CW'(r1_p[i]) - CW'(r1_q[i]);
                r2_s[i]  <= (DW+1)'(r1_a[i]) + (DW+1)'(r1_b[i]);
                r3_e[i]  <= EW'(r2_ma[i]) + EW'(r2_mb[i]) + EW'(r2_c[i]);
                // Edge at (-1,-1): C - (A + B) scaled to the vertex format.
                r3_t[i]  <= EW'(r2_c[i]) - (EW'(r2_s[i]) << F);
                r4_me[i] <= r3_e[i][EW-1] ? EW'(-r3_e[i]) : EW'(r3_e[i]);
            end
        end

        // A zero edge value counts only when the tie-break edge agrees in sign.
        always_comb begin
            if (r3_e[i] != '0) begin
                w_ok[i] = (r3_e[i][EW-1] == r3_d[EW-1]);
            end else begin
                w_ok[i] = (r3_t[i] != '0) && (r3_t[i][EW-1] == r3_d[EW-1]);
            end
        end
    end

    // The opposite-vertex value is the same signed area for every edge.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_da  <= (DW+VW)'(r1_a[0]) * (DW+VW)'(r_vx[0]);
            r2_db  <= (DW+VW)'(r1_b[0]) * (DW+VW)'(r_vy[0]);
            r3_d   <= EW'(r2_da) + EW'(r2_db) + EW'(r2_c[0]);
            r4_cov <= (r3_d != '0) && (&w_ok);
            r4_md  <= r3_d[EW-1] ? EW'(-r3_d) : EW'(r3_d);
        end
    end

    // Stage 5 and the division stages: index 0 holds the numerators.
    logic [NW-1:0]  r_rem [0:CHW][0:2];
    logic [CHW-1:0] r_q   [0:CHW][0:2];
    logic [EW-1:0]  r_dd  [0:CHW];
    logic           r_cv  [0:CHW];
    logic [CHW-1:0] w_ch  [0:2];

    assign w_ch[0] = r_rgb[3*CHW-1:2*CHW];
    assign w_ch[1] = r_rgb[2*CHW-1:CHW];
    assign w_ch[2] = r_rgb[CHW-1:0];

    for (genvar i = 0; i < 3; i++) begin : g_num
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[0][i] <= NW'(r4_me[i]) * NW'(w_ch[i]);
                r_q[0][i]   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd[0] <= r4_md;
            r_cv[0] <= r4_cov;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < CHW; k++) begin : g_div
        localparam int BIT = CHW - 1 - k;
        logic [NW-1:0] w_sh;

        assign w_sh = NW'(r_dd[k]) << BIT;

        for (genvar i = 0; i < 3; i++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (r_rem[k][i] >= w_sh) begin
                        r_rem[k+1][i] <= r_rem[k][i] - w_sh;
                        r_q[k+1][i]   <= r_q[k][i] | (CHW'(1) << BIT);
                    end else begin
                        r_rem[k+1][i] <= r_rem[k][i];
                        r_q[k+1][i]   <= r_q[k][i];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dd[k+1] <= r_dd[k];
                r_cv[k+1] <= r_cv[k];
            end
        end
    end

    // Output register.
    logic           r_o_cov;
    logic [CHW-1:0] r_o_r, r_o_g, r_o_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_cov <= r_cv[CHW];
            r_o_r   <= r_cv[CHW] ? r_q[CHW][0] : '0;
            r_o_g   <= r_cv[CHW] ? r_q[CHW][1] : '0;
            r_o_b   <= r_cv[CHW] ? r_q[CHW][2] : '0;
        end
    end

    assign o_res.valid     = r_vld[NS-1];
    assign o_res.covered   = r_o_cov;
    assign o_res.red_out   = r_o_r;
    assign o_res.green_out = r_o_g;
    assign o_res.blue_out  = r_o_b;

    `TPCS_ASSERT_NOW(a_uncov_zero, o_res.valid && !o_res.covered,
        (o_res.red_out == '0) && (o_res.green_out == '0) && (o_res.blue_out == '0),
        "uncovered pixel carries color")

    `TPCS_ASSERT_NOW(a_degenerate, r_vld[3] && (r4_md == '0), !r4_cov,
        "degenerate triangle marked covered")

    `TPCS_ASSERT_NEXT(a_accept_enters, i_pix.valid && i_pix.ready, r_vld[0],
        "accepted pixel did not enter the pipeline")

endmodule
